// ===== hdl/ibh_pkg.sv =====
// Package: shared constants and types for the indexed binary heap.
package ibh_pkg;
  localparam int unsigned ItemIdsDefault  = 256;
  localparam int unsigned CapacityDefault = 256;
  localparam int unsigned ItemW           = 8;
  localparam int unsigned KeyW            = 32;
  localparam int unsigned OpW             = 2;
  localparam int unsigned StatusW         = 2;
  localparam int unsigned CountW          = 9;

  typedef enum logic [1:0] {
    OP_INSERT  = 2'd0,
    OP_UPDATE  = 2'd1,
    OP_EXTRACT = 2'd2,
    OP_DELETE  = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_ABSENT = 2'd1,
    ST_FULL   = 2'd2,
    ST_EMPTY  = 2'd3
  } status_e;
endpackage

// ===== hdl/indexed_binary_heap.sv =====
// Top level: indexed binary heap priority queue with a sequenced sift engine.
//
// One word in, one word out. Each operation runs on a small sequencer over
// one-read, one-write slot and position memories with one shared key
// comparator. Extract and delete also fetch the last entry when it must be
// moved. Each level walked down takes a left read, a right read, a child
// compare, then a compare and move; each level walked up takes a parent
// read, then a compare and move. A stalled result word holds off the next
// input. After reset a clearing pass sweeps the position table before the
// first word is accepted. The order bit written through cfg_we_i selects
// the heap: 0 is a min heap, 1 a max heap.
module indexed_binary_heap
  import ibh_pkg::*;
#(
  parameter int unsigned ITEM_IDS = ItemIdsDefault,
  parameter int unsigned CAPACITY = CapacityDefault
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic        cfg_wdata_i,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // tdata: op[1:0], item[9:2], key[41:10], zero fill [47:42]
  input  logic [47:0] s_axis_tdata,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // tdata: status[1:0], top_item[9:2], count[18:10], zero fill [23:19]
  output logic [23:0] m_axis_tdata
);
  localparam int unsigned SW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int unsigned IW = (ITEM_IDS > 1) ? $clog2(ITEM_IDS) : 1;
  localparam int unsigned NW = $clog2(CAPACITY + 1);

  typedef enum logic [12:0] {
    S_CLR   = 13'h0001, S_IDLE  = 13'h0002, S_LOOK  = 13'h0004,
    S_DISP  = 13'h0008, S_LAST  = 13'h0010, S_DNL   = 13'h0020,
    S_DNR   = 13'h0040, S_DNC   = 13'h0080, S_DNM   = 13'h0100,
    S_UPR   = 13'h0200, S_UPC   = 13'h0400, S_FIN   = 13'h0800,
    S_RES   = 13'h1000
  } state_e;

  state_e state_q, state_d;

  // memories
  logic [ItemW-1:0] item_mem [CAPACITY];
  logic [KeyW-1:0]  key_mem  [CAPACITY];
  logic [SW:0]      pos_mem  [ITEM_IDS];   // msb = present

  logic             m_we, p_we;
  logic [SW-1:0]    m_wa, m_ra;
  logic [ItemW-1:0] m_wi;
  logic [KeyW-1:0]  m_wk;
  logic [ItemW-1:0] m_ri_q;
  logic [KeyW-1:0]  m_rk_q;
  logic [IW-1:0]    p_wa, p_ra;
  logic [SW:0]      p_wd, p_rd_q;

  always_ff @(posedge clk_i) begin
    if (m_we) begin
      item_mem[m_wa] <= m_wi;
      key_mem[m_wa]  <= m_wk;
    end
    m_ri_q <= item_mem[m_ra];
    m_rk_q <= key_mem[m_ra];
    if (p_we) pos_mem[p_wa] <= p_wd;
    p_rd_q <= pos_mem[p_ra];
  end

  logic             order_q;
  logic [NW-1:0]    cnt_q, cnt_d;
  logic [OpW-1:0]   op_q, op_d;
  logic [ItemW-1:0] it_q, it_d, top_q, top_d, li_q, li_d;
  logic [KeyW-1:0]  k_q, k_d, lk_q, lk_d;
  logic [SW-1:0]    i_q, i_d, m_q, m_d;
  logic             updn_q, updn_d;   // run sift up after sift down
  logic [1:0]       st_q, st_d;
  logic [IW:0]      clr_q, clr_d;
  logic             ov_q, ov_d;
  logic [23:0]      od_q, od_d;

  // shared comparator: a ranks strictly above b
  logic [KeyW-1:0] ca, cb;
  logic            above;
  assign above = order_q ? ($signed(ca) > $signed(cb)) : ($signed(ca) < $signed(cb));

  logic [SW:0] lch, rch, cnt_x;
  assign lch   = {i_q, 1'b1};
  assign rch   = {i_q, 1'b1} + (SW+1)'(1);
  assign cnt_x = (SW+1)'(cnt_q);
  logic [SW-1:0] par;
  assign par = SW'((i_q - SW'(1)) >> 1);

  logic in_rng;
  assign in_rng = (ITEM_IDS >= 256) || (32'(it_q) < ITEM_IDS);

  assign s_axis_tready = (state_q == S_IDLE) && !ov_q;
  assign m_axis_tvalid = ov_q;
  assign m_axis_tdata  = od_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) order_q <= 1'b0;
    else if (cfg_we_i) order_q <= cfg_wdata_i;
  end

  always_comb begin
    state_d = state_q; cnt_d = cnt_q; op_d = op_q; it_d = it_q; top_d = top_q;
    k_d = k_q; lk_d = lk_q; li_d = li_q; i_d = i_q; m_d = m_q; updn_d = updn_q;
    st_d = st_q; clr_d = clr_q; ov_d = ov_q; od_d = od_q;
    m_we = 1'b0; m_wa = i_q; m_wi = li_q; m_wk = lk_q; m_ra = i_q;
    p_we = 1'b0; p_wa = IW'(li_q); p_wd = {1'b1, i_q}; p_ra = IW'(it_q);
    ca = m_rk_q; cb = k_q;
    if (ov_q && m_axis_tready) ov_d = 1'b0;
    unique case (state_q)
      S_CLR: begin
        p_we = 1'b1; p_wa = clr_q[IW-1:0]; p_wd = '0;
        clr_d = clr_q + (IW+1)'(1);
        if (clr_q == (IW+1)'(ITEM_IDS - 1)) state_d = S_IDLE;
      end
      S_IDLE: if (s_axis_tvalid && s_axis_tready) begin
        op_d = s_axis_tdata[1:0]; it_d = s_axis_tdata[9:2];
        k_d = s_axis_tdata[41:10]; st_d = ST_OK; top_d = '0;
        state_d = S_LOOK;
      end
      S_LOOK: begin  // pos read of item; slot 0 read for extract
        m_ra = '0; state_d = S_DISP;
      end
      S_DISP: begin
        updn_d = 1'b1;
        unique case (op_e'(op_q))
          OP_EXTRACT: begin
            if (cnt_q == '0) begin
              st_d = ST_EMPTY; state_d = S_RES;
            end else begin
              top_d = m_ri_q; cnt_d = cnt_q - NW'(1);
              p_we = 1'b1; p_wa = IW'(m_ri_q); p_wd = '0;
              i_d = '0; updn_d = 1'b0;
              m_ra = SW'(cnt_q - NW'(1));
              state_d = (cnt_q == NW'(1)) ? S_RES : S_LAST;
            end
          end
          OP_INSERT, OP_UPDATE: begin
            if (!in_rng || (!p_rd_q[SW] && op_q == OP_UPDATE)) begin
              st_d = ST_ABSENT; state_d = S_RES;
            end else if (p_rd_q[SW]) begin
              i_d = p_rd_q[SW-1:0]; state_d = S_DNL;
            end else if (cnt_q >= NW'(CAPACITY)) begin
              st_d = ST_FULL; state_d = S_RES;
            end else begin
              i_d = SW'(cnt_q); cnt_d = cnt_q + NW'(1); state_d = S_UPR;
            end
          end
          default: begin  // delete
            if (!in_rng || !p_rd_q[SW]) begin
              st_d = ST_ABSENT; state_d = S_RES;
            end else begin
              p_we = 1'b1; p_wa = IW'(it_q); p_wd = '0;
              i_d = p_rd_q[SW-1:0]; cnt_d = cnt_q - NW'(1);
              m_ra = SW'(cnt_q - NW'(1));
              state_d = (NW'(p_rd_q[SW-1:0]) == cnt_q - NW'(1)) ? S_RES : S_LAST;
            end
          end
        endcase
      end
      S_LAST: begin  // last entry data valid
        it_d = m_ri_q; k_d = m_rk_q; state_d = S_DNL;
      end
      S_DNL: begin
        if (lch < cnt_x) begin
          m_ra = lch[SW-1:0]; m_d = lch[SW-1:0]; state_d = S_DNR;
        end else state_d = updn_q ? S_UPR : S_FIN;
      end
      S_DNR: begin  // left child data valid
        lk_d = m_rk_q; li_d = m_ri_q;
        m_ra = rch[SW-1:0]; state_d = S_DNC;
      end
      S_DNC: begin  // right child data valid; left wins ties
        ca = m_rk_q; cb = lk_q;
        if (rch < cnt_x && above) begin
          lk_d = m_rk_q; li_d = m_ri_q; m_d = rch[SW-1:0];
        end
        state_d = S_DNM;
      end
      S_DNM: begin  // move chosen child up into slot i
        ca = lk_q; cb = k_q;
        if (above) begin
          m_we = 1'b1; p_we = 1'b1;
          i_d = m_q; state_d = S_DNL;
        end else state_d = updn_q ? S_UPR : S_FIN;
      end
      S_UPR: begin
        if (i_q == '0) state_d = S_FIN;
        else begin
          m_ra = par; m_d = par; state_d = S_UPC;
        end
      end
      S_UPC: begin  // parent data valid; move it down into slot i
        ca = k_q; cb = m_rk_q;
        if (above) begin
          m_we = 1'b1; m_wi = m_ri_q; m_wk = m_rk_q;
          p_we = 1'b1; p_wa = IW'(m_ri_q);
          i_d = m_q; state_d = S_UPR;
        end else state_d = S_FIN;
      end
      S_FIN: begin
        m_we = 1'b1; m_wa = i_q; m_wi = it_q; m_wk = k_q;
        p_we = 1'b1; p_wa = IW'(it_q); p_wd = {1'b1, i_q};
        state_d = S_RES;
      end
      S_RES: if (!ov_q || m_axis_tready) begin
        ov_d = 1'b1;
        od_d = {5'b0, 9'(cnt_q), (st_q == ST_OK) ? top_q : 8'd0, st_q};
        state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLR; cnt_q <= '0; clr_q <= '0; ov_q <= 1'b0; st_q <= ST_OK;
      op_q <= '0; updn_q <= 1'b0;
    end else begin
      state_q <= state_d; cnt_q <= cnt_d; clr_q <= clr_d; ov_q <= ov_d; st_q <= st_d;
      op_q <= op_d; updn_q <= updn_d;
    end
  end

  always_ff @(posedge clk_i) begin
    it_q <= it_d; top_q <= top_d; k_q <= k_d; lk_q <= lk_d; li_q <= li_d;
    i_q <= i_d; m_q <= m_d; od_q <= od_d;
  end
endmodule

// ===== hdl/ibh_checker.sv =====
// Checker: port-level properties of the indexed binary heap, with its bind.
module ibh_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [23:0] m_axis_tdata
);
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("output word dropped while stalled");
  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("accepted a word while busy");
  a_cnt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> m_axis_tdata[18:10] <= 9'd256)
    else $error("count out of range");
  a_top: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tdata[1:0] != 2'd0 |-> m_axis_tdata[9:2] == 8'd0)
    else $error("top item on error");
endmodule

bind indexed_binary_heap ibh_checker u_ibh_checker (.*);

// ===== tb/sv/indexed_binary_heap_tb.sv =====
// Testbench for indexed_binary_heap: directed and randomized heap operations checked against a built-in heap model.
module indexed_binary_heap_tb;
  import ibh_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    status_e          status;
    logic [ItemW-1:0] top_item;
    logic [CountW-1:0] count;
  } heap_reply_t;

  class heap_scoreboard;
    bit                       max_order;
    bit                       present[256];
    int unsigned              slot_of[256];
    logic [ItemW-1:0]         slot_item[256];
    logic signed [KeyW-1:0]   slot_key[256];
    int unsigned              entries;
    heap_reply_t              replies[$];
    int unsigned              errors;

    function bit ranks_above(logic signed [KeyW-1:0] a, logic signed [KeyW-1:0] b);
      return max_order ? (a > b) : (a < b);
    endfunction

    function void place(int unsigned slot, logic [ItemW-1:0] it, logic signed [KeyW-1:0] k);
      slot_item[slot] = it;
      slot_key[slot]  = k;
      slot_of[it]     = slot;
      present[it]     = 1'b1;
    endfunction

    function void sift_down(logic [ItemW-1:0] it, logic signed [KeyW-1:0] k);
      int unsigned i, m;
      i = slot_of[it];
      while (2 * i + 1 < entries) begin
        m = 2 * i + 1;
        if (m + 1 < entries && ranks_above(slot_key[m+1], slot_key[m])) m = m + 1;
        if (!ranks_above(slot_key[m], k)) break;
        place(i, slot_item[m], slot_key[m]);
        i = m;
      end
      place(i, it, k);
    endfunction

    function void sift_up(logic [ItemW-1:0] it, logic signed [KeyW-1:0] k);
      int unsigned i, p;
      i = slot_of[it];
      while (i > 0) begin
        p = (i - 1) / 2;
        if (!ranks_above(k, slot_key[p])) break;
        place(i, slot_item[p], slot_key[p]);
        i = p;
      end
      place(i, it, k);
    endfunction

    function void rekey(logic [ItemW-1:0] it, logic signed [KeyW-1:0] k);
      sift_down(it, k);
      sift_up(it, k);
    endfunction

    function void note_word(op_e op, logic [ItemW-1:0] it, logic signed [KeyW-1:0] k);
      heap_reply_t r;
      logic [ItemW-1:0] li;
      logic signed [KeyW-1:0] lk;
      int unsigned i;
      r.status   = ST_OK;
      r.top_item = '0;
      case (op)
        OP_EXTRACT: begin
          if (entries == 0) r.status = ST_EMPTY;
          else begin
            r.top_item = slot_item[0];
            present[slot_item[0]] = 1'b0;
            entries--;
            if (entries > 0) begin
              li = slot_item[entries];
              lk = slot_key[entries];
              place(0, li, lk);
              sift_down(li, lk);
            end
          end
        end
        OP_INSERT: begin
          if (present[it]) rekey(it, k);
          else if (entries >= 256) r.status = ST_FULL;
          else begin
            place(entries, it, k);
            entries++;
            sift_up(it, k);
          end
        end
        OP_UPDATE: begin
          if (present[it]) rekey(it, k);
          else r.status = ST_ABSENT;
        end
        default: begin
          if (!present[it]) r.status = ST_ABSENT;
          else begin
            i = slot_of[it];
            present[it] = 1'b0;
            entries--;
            if (entries != i) begin
              li = slot_item[entries];
              lk = slot_key[entries];
              place(i, li, lk);
              rekey(li, lk);
            end
          end
        end
      endcase
      r.count = entries[CountW-1:0];
      replies.push_back(r);
    endfunction

    function void check_word(logic [23:0] data);
      heap_reply_t e;
      if (replies.size() == 0) begin
        $error("unexpected result word %h", data);
        errors++;
        return;
      end
      e = replies.pop_front();
      if (data[1:0] !== e.status) begin
        $error("status: expected %0d, got %0d", e.status, data[1:0]);
        errors++;
      end
      if (data[9:2] !== e.top_item) begin
        $error("top_item: expected %0d, got %0d", e.top_item, data[9:2]);
        errors++;
      end
      if (data[18:10] !== e.count) begin
        $error("count: expected %0d, got %0d", e.count, data[18:10]);
        errors++;
      end
    endfunction
  endclass

  logic        clk_i = 1'b0;
  logic        rst_ni;
  logic        cfg_we_i;
  logic        cfg_wdata_i;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [47:0] s_axis_tdata;
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [23:0] m_axis_tdata;

  heap_scoreboard heap_sb = new();
  bit quiet;
  bit hold_rx;
  bit tx_high;
  int unsigned idle_cycles;

  indexed_binary_heap DUT (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_wdata_i,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata
  );

  initial forever #5 clk_i = ~clk_i;

  function int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (quiet || r < 65) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(20, 60);
  endfunction

  function logic signed [KeyW-1:0] pick_key();
    case ($urandom_range(0, 3))
      0: return $signed($urandom_range(0, 8)) - 4;
      1: return $urandom_range(0, 1) ? 32'sh7fffffff : 32'sh80000000;
      default: return $urandom;
    endcase
  endfunction

  task automatic send_word(op_e op, logic [ItemW-1:0] it, logic signed [KeyW-1:0] k);
    int unsigned g;
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {6'b0, k, it, op};
    tx_high = 1'b1;
    do @(posedge clk_i); while (!s_axis_tready);
    heap_sb.note_word(op, it, k);
    g = pick_gap();
    if (g > 0) begin
      s_axis_tvalid <= 1'b0;
      tx_high = 1'b0;
      repeat (g) @(posedge clk_i);
    end
  endtask

  task automatic drain();
    if (tx_high) begin
      s_axis_tvalid <= 1'b0;
      tx_high = 1'b0;
      @(posedge clk_i);
    end
    while (heap_sb.replies.size() != 0) @(posedge clk_i);
    repeat (100) @(posedge clk_i);
  endtask

  task automatic write_order(bit v);
    drain();
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= v;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    heap_sb.max_order = v;
  endtask

  task automatic random_words(int unsigned n, int unsigned pause_at);
    int unsigned r;
    op_e op;
    logic [ItemW-1:0] it;
    for (int unsigned i = 0; i < n; i++) begin
      if (i == pause_at) drain();
      if (i % 120 == 60) quiet = ~quiet;
      r  = $urandom_range(0, 99);
      op = r < 40 ? OP_INSERT : r < 60 ? OP_UPDATE : r < 80 ? OP_EXTRACT : OP_DELETE;
      it = $urandom_range(0, 3) == 0 ? 8'($urandom_range(0, 255)) : 8'($urandom_range(0, 39));
      send_word(op, it, pick_key());
    end
    quiet = 1'b0;
  endtask

  // receiver: random backpressure plus one long hold-off on request
  initial begin
    int unsigned g;
    m_axis_tready <= 1'b0;
    forever begin
      if (hold_rx) begin
        m_axis_tready <= 1'b0;
        repeat (400) @(posedge clk_i);
        hold_rx = 1'b0;
      end else begin
        g = pick_gap();
        if (g > 0) begin
          m_axis_tready <= 1'b0;
          repeat (g) @(posedge clk_i);
        end
      end
      m_axis_tready <= 1'b1;
      @(posedge clk_i);
    end
  end

  initial begin
    forever begin
      @(posedge clk_i);
      if (m_axis_tvalid && m_axis_tready) heap_sb.check_word(m_axis_tdata);
      if ((m_axis_tvalid && m_axis_tready) || (s_axis_tvalid && s_axis_tready))
        idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= 5000) begin
        $display("Verification failed");
        $finish;
      end
    end
  end

  initial begin
    rst_ni        <= 1'b0;
    cfg_we_i      <= 1'b0;
    cfg_wdata_i   <= 1'b0;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata  <= '0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    write_order(1'b0);

    // directed: errors on empty heap, key extremes, ties, re-insert, delete
    send_word(OP_EXTRACT, 8'd0, 0);
    send_word(OP_DELETE, 8'd7, 0);
    send_word(OP_UPDATE, 8'd255, 0);
    send_word(OP_INSERT, 8'd0, 32'sh7fffffff);
    send_word(OP_INSERT, 8'd255, 32'sh80000000);
    send_word(OP_INSERT, 8'd170, 0);
    send_word(OP_INSERT, 8'd85, 0);
    send_word(OP_INSERT, 8'd1, -1);
    send_word(OP_INSERT, 8'd2, -1);
    send_word(OP_UPDATE, 8'd255, 32'sh7fffffff);
    send_word(OP_INSERT, 8'd0, 32'sh80000000);
    send_word(OP_DELETE, 8'd170, 0);
    send_word(OP_DELETE, 8'd170, 0);
    send_word(OP_UPDATE, 8'd3, 5);
    send_word(OP_EXTRACT, 8'd0, 0);
    send_word(OP_EXTRACT, 8'd0, 0);
    send_word(OP_DELETE, 8'd255, 0);
    send_word(OP_EXTRACT, 8'd0, 0);
    send_word(OP_EXTRACT, 8'd0, 0);
    send_word(OP_EXTRACT, 8'd0, 0);

    write_order(1'b1);
    fork
      random_words(300, 150);
      begin
        repeat (200) @(posedge clk_i);
        hold_rx = 1'b1;
      end
    join

    write_order(1'b0);
    for (int unsigned i = 0; i < 256; i++) send_word(OP_INSERT, 8'(i), pick_key());
    random_words(150, 1000);

    write_order(1'b1);
    random_words(220, 1000);
    for (int unsigned i = 0; i < 60; i++) send_word(OP_EXTRACT, 8'($urandom), 0);

    drain();
    if (heap_sb.errors == 0) $display("Verification passed");
    else $display("Verification failed");
    $finish;
  end
endmodule
